// ----- hw/rtl/fir_cb_pkg.sv -----
// Shared widths, limits and control types of the FIR filter.
`timescale 1ns / 1ps
`default_nettype none
package fir_cb_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned OutWidth = 17;
  localparam int          OutMax   = 65535;
  localparam int          OutMin   = -65536;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // start of a new sum
    logic valid;  // history read data is a tap to accumulate
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fir_cb_if.sv -----
// Request channel interfaces: input samples and filtered results.
`timescale 1ns / 1ps
`default_nettype none
interface fir_cb_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fir_cb_pkg::InWidth-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir_cb_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fir_cb_pkg::OutWidth-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fir_cb_hist.sv -----
// Circular sample history: synchronous memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fir_cb_hist #(
  parameter int unsigned Depth = 20,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrW = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic signed [Width-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output      logic signed [Width-1:0] rdata_o
);

  logic signed [Width-1:0] mem [Depth];
  logic [Depth-1:0]        vld_q;
  logic signed [Width-1:0] rdata_q;
  logic                    rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // Entries not written since reset read as zero.
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/fir_cb_mac.sv -----
// Shared multiply-accumulate: registered product, then running sum.
`timescale 1ns / 1ps
`default_nettype none
module fir_cb_mac #(
  parameter int unsigned SampleWidth = 16,
  parameter int unsigned CoefWidth   = 16,
  parameter int unsigned AccWidth    = 38
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fir_cb_pkg::mac_ctrl_t         ctrl_i,
  input  wire logic signed [SampleWidth-1:0] sample_i,
  output      logic signed [AccWidth-1:0]    acc_o,
  output      logic                          busy_o
);

  localparam int unsigned ProdWidth = SampleWidth + CoefWidth;
  // 0.1 in Q1.(CoefWidth-1), rounded to nearest.
  localparam logic signed [CoefWidth-1:0] Coef =
    CoefWidth'(((1 << (CoefWidth - 1)) + 5) / 10);

  logic signed [ProdWidth-1:0] prod_q;
  logic                        prod_vld_q;
  logic signed [AccWidth-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= sample_i * Coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + AccWidth'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fir_filter_circular_buffer.sv -----
// Direct-form FIR filter over a circular sample history (top level).
//
// Channels: sample_if_i takes one signed 16-bit sample per request, result_if_o
// gives one 17-bit signed filtered sample per accepted input, in order.
// Each accepted sample is written into the history memory; the sequencer then
// reads the TAPS most recent samples newest first, one per cycle, through the
// single memory read port into one shared multiplier and accumulator.
// The sum is rounded half up, shifted by COEF_WIDTH-1 and saturated.
// One sample is in flight at a time; throughput is set by the history port,
// which gives one read per cycle, and by the idle state in which the next
// request is taken.
// Input ready is high only while the sequencer is idle. A finished result sits
// in the output register; a new sample is taken while it waits, and its sum
// is held until the receiver has taken the earlier result.
// Reset clears the write index and the history valid bits at once, so the
// history reads as zeros straight after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fir_filter_circular_buffer #(
  parameter int unsigned TAPS         = 20,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  fir_cb_sample_if.sink   sample_if_i,
  fir_cb_result_if.source result_if_o
);

  localparam int unsigned AddrW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned AccW   = SAMPLE_WIDTH + COEF_WIDTH + AddrW + 1;
  localparam int unsigned OutW   = fir_cb_pkg::OutWidth;
  localparam int unsigned RndW   = AccW + OutW + 1;
  localparam int unsigned Shift  = COEF_WIDTH - 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(TAPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] rp_q, rp_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             rd_vld_q;
  logic             out_vld_q;
  logic signed [OutW-1:0] out_q;

  logic                           in_acc;
  logic                           rd_en;
  logic                           out_free;
  logic signed [SAMPLE_WIDTH-1:0] sample_ext;
  logic signed [SAMPLE_WIDTH-1:0] hist_rdata;
  logic signed [AccW-1:0]         acc;
  logic                           mac_busy;
  fir_cb_pkg::mac_ctrl_t          mac_ctrl;
  logic signed [RndW-1:0]         rnd_sum;
  logic signed [RndW-1:0]         shifted;
  logic signed [OutW-1:0]         sat_val;

  assign in_acc   = sample_if_i.valid && sample_if_i.ready;
  assign out_free = !out_vld_q || result_if_o.ready;
  assign rd_en    = (state_q == ST_RUN);

  // Port bits above SAMPLE_WIDTH are dropped; sign comes from the top kept bit.
  assign sample_ext = signed'(SAMPLE_WIDTH'(unsigned'(sample_if_i.sample_in)));

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rp_d    = wp_q;
          wp_d    = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rp_d  = (rp_q == '0) ? LastIdx : rp_q - 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_en;
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (result_if_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_q <= sat_val;
    end
  end

  fir_cb_hist #(
    .Depth (TAPS),
    .Width (SAMPLE_WIDTH),
    .AddrW (AddrW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (sample_ext),
    .re_i    (rd_en),
    .raddr_i (rp_q),
    .rdata_o (hist_rdata)
  );

  assign mac_ctrl.clear = in_acc;
  assign mac_ctrl.valid = rd_vld_q;

  fir_cb_mac #(
    .SampleWidth (SAMPLE_WIDTH),
    .CoefWidth   (COEF_WIDTH),
    .AccWidth    (AccW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (hist_rdata),
    .acc_o    (acc),
    .busy_o   (mac_busy)
  );

  // Round half up, floor shift, clamp to the 17-bit range.
  always_comb begin
    rnd_sum = RndW'(acc) + (RndW'(1) <<< (Shift - 1));
    shifted = rnd_sum >>> Shift;
    priority if (shifted > RndW'(fir_cb_pkg::OutMax)) begin
      sat_val = OutW'(fir_cb_pkg::OutMax);
    end else if (shifted < RndW'(fir_cb_pkg::OutMin)) begin
      sat_val = OutW'(fir_cb_pkg::OutMin);
    end else begin
      sat_val = OutW'(shifted);
    end
  end

  assign sample_if_i.ready        = (state_q == ST_IDLE);
  assign result_if_o.valid        = out_vld_q;
  assign result_if_o.filtered_out = out_q;

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN))
    else $error("accepted sample did not start a tap sweep");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LastIdx)
    else $error("history write index beyond last entry");

  a_fin_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (!rd_vld_q && !mac_busy))
    else $error("sum finalised with taps still in flight");

  a_idle_mac_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mac_busy && !rd_vld_q))
    else $error("accumulator active while sequencer idle");

endmodule
`default_nettype wire

// ----- dv/tb_fir_filter_circular_buffer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the circular-buffer FIR filter: directed and random samples.
module tb_fir_filter_circular_buffer;

  localparam int unsigned Taps     = 20;
  localparam int unsigned FracBits = 15;
  // 0.1 in Q1.15, rounded to nearest
  localparam longint      TapCoef  = ((longint'(1) << FracBits) + 5) / 10;
  localparam int unsigned DrainMax = 20000;

  typedef enum int unsigned {
    RecvAlways,
    RecvRandom,
    RecvLong
  } recv_mode_e;

  logic clk;
  logic rst_n;

  fir_cb_sample_if sample_if ();
  fir_cb_result_if result_if ();

  fir_filter_circular_buffer #(
    .TAPS        (Taps),
    .SAMPLE_WIDTH(16),
    .COEF_WIDTH  (16)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_if_i(sample_if),
    .result_if_o(result_if)
  );

  logic signed [fir_cb_pkg::InWidth-1:0]  history [Taps];
  int unsigned                            wr_idx;
  logic signed [fir_cb_pkg::OutWidth-1:0] filtered_q [$];
  logic signed [fir_cb_pkg::OutWidth-1:0] want;
  int unsigned                            error_count;
  bit                                     gaps_on;
  int unsigned                            burst_left;
  recv_mode_e                             recv_mode;
  int unsigned                            stall_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Writes the sample into the history and returns the filtered value it yields.
  function automatic logic signed [fir_cb_pkg::OutWidth-1:0] filter_sample(
    input logic signed [fir_cb_pkg::InWidth-1:0] s
  );
    longint acc;
    longint q;
    history[wr_idx] = s;
    wr_idx = (wr_idx + 1 == Taps) ? 0 : wr_idx + 1;
    acc = 0;
    for (int k = 0; k < Taps; k++) begin
      acc += TapCoef * longint'(history[k]);
    end
    // half an LSB, then floor shift: ties go towards plus infinity
    acc += longint'(1) << (FracBits - 1);
    q = acc >>> FracBits;
    if (q < fir_cb_pkg::OutMin) q = fir_cb_pkg::OutMin;
    if (q > fir_cb_pkg::OutMax) q = fir_cb_pkg::OutMax;
    return q[fir_cb_pkg::OutWidth-1:0];
  endfunction

  function automatic logic signed [fir_cb_pkg::InWidth-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 16'($urandom());
    if (pick < 8) return $signed(16'($urandom_range(0, 600))) - 16'sd300;
    return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic send_sample(input logic signed [fir_cb_pkg::InWidth-1:0] s);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 30);
        @(negedge clk);
        sample_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    sample_if.valid     <= 1'b1;
    sample_if.sample_in <= s;
    do @(posedge clk); while (!sample_if.ready);
    filtered_q.push_back(filter_sample(s));
  endtask

  // Receiver ready pattern
  always @(negedge clk) begin
    case (recv_mode)
      RecvAlways: begin
        result_if.ready <= 1'b1;
      end
      RecvRandom: begin
        result_if.ready <= ($urandom_range(0, 99) >= 35);
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          result_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(5, 40);
          result_if.ready <= 1'b0;
        end else begin
          result_if.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (filtered_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected filtered_out %0d, nothing outstanding", $time,
                 result_if.filtered_out);
      end else begin
        want = filtered_q.pop_front();
        if (result_if.filtered_out !== want) begin
          error_count++;
          $display("%0t: filtered_out mismatch: expected %0d, got %0d", $time, want,
                   result_if.filtered_out);
        end
      end
    end
  end

  // First request after reset reads a zero history; the first one is a
  // negative rounding tie, the run of minimum samples ends in saturation.
  task automatic test_directed_edges();
    gaps_on   = 1'b0;
    recv_mode = RecvAlways;
    send_sample(-16'sd16384);
    send_sample(16'sd16384);
    send_sample(16'sd0);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    repeat (Taps) send_sample(16'sh8000);
  endtask

  task automatic test_random_samples(input int unsigned n);
    gaps_on   = 1'b1;
    recv_mode = RecvRandom;
    repeat (n) send_sample(rand_sample());
  endtask

  // Long runs at or near the rails so the sum crosses the output limits.
  task automatic test_saturation_runs();
    bit neg;
    int unsigned run_len;
    gaps_on   = 1'b1;
    recv_mode = RecvLong;
    repeat (8) begin
      neg     = $urandom_range(0, 1);
      run_len = $urandom_range(Taps, Taps + 10);
      repeat (run_len) begin
        if ($urandom_range(0, 3) == 0)
          send_sample(neg ? 16'sh8000 + 16'($urandom_range(0, 40))
                          : 16'sd32767 - 16'($urandom_range(0, 40)));
        else
          send_sample(neg ? 16'sh8000 : 16'sh7fff);
      end
      repeat ($urandom_range(0, 4)) send_sample(rand_sample());
    end
  endtask

  // Sums of multiples of 16384 land on an integer or exactly on half an LSB after the shift.
  task automatic test_rounding_ties(input int unsigned n);
    gaps_on   = 1'b0;
    recv_mode = RecvRandom;
    repeat (n) send_sample(16'($urandom_range(0, 3) * 16384) - 16'sh8000);
  endtask

  task automatic test_backpressure(input int unsigned n);
    gaps_on   = 1'b0;
    recv_mode = RecvLong;
    repeat (n / 2) send_sample(rand_sample());
    gaps_on = 1'b1;
    repeat (n - n / 2) send_sample(rand_sample());
  endtask

  initial begin
    int unsigned waited;
    sample_if.valid     = 1'b0;
    sample_if.sample_in = '0;
    result_if.ready     = 1'b0;
    recv_mode           = RecvAlways;
    stall_left          = 0;
    gaps_on             = 1'b0;
    burst_left          = 0;
    error_count         = 0;
    wr_idx              = 0;
    for (int k = 0; k < Taps; k++) history[k] = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_random_samples(350);
    test_saturation_runs();
    test_rounding_ties(120);
    test_backpressure(200);

    @(negedge clk);
    sample_if.valid <= 1'b0;
    recv_mode = RecvAlways;
    waited = 0;
    while (filtered_q.size() != 0 && waited < DrainMax) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * (Taps + 4)) @(posedge clk);
    if (filtered_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d filtered results never arrived", $time, filtered_q.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
